// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CHECK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: hdl/tio_pkg.sv
// ----------------------------------------------------------------------------
// Tick I/O controller package
// Sizes, command codes and word types shared by the controller and its channels.
// ----------------------------------------------------------------------------
package tio_pkg;

  localparam int LED_COUNT    = 12;
  localparam int BLANK_SWEEPS = 6;
  localparam int PULSE_COUNT  = 8;

  localparam int LED_AW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int BLANK_W  = (BLANK_SWEEPS > 1) ? $clog2(BLANK_SWEEPS) : 1;
  localparam int PULSE_AW = (PULSE_COUNT > 1) ? $clog2(PULSE_COUNT) : 1;

  localparam logic [3:0]  DAC_CMD_CH0 = 4'h3;
  localparam logic [3:0]  DAC_CMD_CH1 = 4'hB;
  localparam logic [11:0] DAC_MID     = 12'd2048;
  localparam logic [7:0]  COUNT_HOLD  = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LED   = 2'd1,
    FUNC_PULSE = 2'd2,
    FUNC_CV    = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [3:0]  index;
    logic [7:0]  on_time;
    logic [7:0]  off_time;
    logic [11:0] value;
  } cmd_t;

  typedef struct packed {
    logic [11:0] led_lines;
    logic [7:0]  pulse_lines;
    logic        dac_word_valid;
    logic [15:0] dac_word;
  } res_t;

  // One blink table entry.
  typedef struct packed {
    logic [7:0] on_left;
    logic [7:0] off_left;
    logic [7:0] on_reload;
    logic [7:0] off_reload;
  } led_entry_t;

endpackage

// File: hdl/tio_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Carries one command word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface tio_cmd_if;
  import tio_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/tio_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one result word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface tio_res_if;
  import tio_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/tio_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Writes the force-zero mode register.
// ----------------------------------------------------------------------------
interface tio_cfg_if;
  logic valid;
  logic ready;
  logic force_zero_mode;

  modport source (output valid, output force_zero_mode, input ready);
  modport sink (input valid, input force_zero_mode, output ready);
endinterface

// File: hdl/tick_io_controller.sv
// ----------------------------------------------------------------------------
// Tick I/O controller
// Tick-driven LED blink, pulse output and DAC update controller.
// ----------------------------------------------------------------------------
// The block takes one command word per clock cycle unless the work stage is
// stalled, and returns exactly one result word for each, through the work
// stage and an output register so that a stalled result does not block the
// next command. The LED blink table is a memory of LED_COUNT entries: a tick
// reads the entry under the LED cursor when it is accepted and writes it back
// when the work stage advances, with a bypass from the last write, so ticks
// run back to back. Entries carry valid bits cleared by reset, so no clearing
// pass is needed. Pulse counters and both DAC channels are kept in registers.
`include "assert_macros.svh"

module tick_io_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  tio_cmd_if.sink    cmd_i,
  tio_res_if.source  res_o,
  tio_cfg_if.sink    cfg_i
);
  import tio_pkg::*;

  // Accept side.
  logic               cmd_fire;
  logic               force_zero_q;
  logic [1:0]         phase_q;
  logic [LED_AW-1:0]  cursor_q;
  logic [BLANK_W-1:0] blank_sweep_q;

  // Work stage.
  logic               b_valid_q;
  logic               b_adv;
  cmd_t               b_cmd_q;
  logic [1:0]         b_phase_q;
  logic [LED_AW-1:0]  b_cursor_q;
  logic [BLANK_W-1:0] b_blank_q;

  // Blink table memory and its bypass.
  led_entry_t         led_mem [LED_COUNT];
  led_entry_t         led_rdata_q;
  logic [LED_COUNT-1:0] led_valid_q;
  logic               mem_we;
  logic [LED_AW-1:0]  mem_waddr;
  led_entry_t         mem_wdata;
  logic               fwd_valid_q;
  logic [LED_AW-1:0]  fwd_addr_q;
  led_entry_t         fwd_data_q;
  led_entry_t         ent_rd;

  // Architectural state.
  logic [LED_COUNT-1:0]   led_drive_q, led_drive_d;
  logic [PULSE_COUNT-1:0] pulse_drive_q, pulse_drive_d;
  logic [PULSE_COUNT-1:0][7:0] pulse_left_q, pulse_left_d;
  logic [1:0][11:0]       dac_sent_q, dac_sent_d;
  logic [1:0][11:0]       dac_target_q, dac_target_d;

  // Output register.
  logic out_valid_q;
  res_t out_q;
  res_t res_d;

  assign cfg_i.ready = 1'b1;

  assign b_adv       = b_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !b_valid_q || b_adv;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_zero_q <= 1'b0;
    end else if (cfg_i.valid) begin
      force_zero_q <= cfg_i.force_zero_mode;
    end
  end

  // Tick phase, LED cursor and blank sweep depend only on the order of ticks,
  // so they advance at acceptance and travel with the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      cursor_q      <= '0;
      blank_sweep_q <= '0;
    end else if (cmd_fire && cmd_i.data.func == FUNC_TICK) begin
      phase_q <= phase_q + 2'd1;
      if (cursor_q == LED_AW'(LED_COUNT - 1)) begin
        cursor_q <= '0;
        if (blank_sweep_q == BLANK_W'(BLANK_SWEEPS - 1)) begin
          blank_sweep_q <= '0;
        end else begin
          blank_sweep_q <= blank_sweep_q + BLANK_W'(1);
        end
      end else begin
        cursor_q <= cursor_q + LED_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (cmd_fire) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      b_cmd_q    <= cmd_i.data;
      b_phase_q  <= phase_q;
      b_cursor_q <= cursor_q;
      b_blank_q  <= blank_sweep_q;
    end
  end

  // Blink table: read on tick acceptance, written back from the work stage.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      led_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_fire && cmd_i.data.func == FUNC_TICK) begin
      led_rdata_q <= led_mem[cursor_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_valid_q <= '0;
      fwd_valid_q <= 1'b0;
    end else if (mem_we) begin
      led_valid_q[mem_waddr] <= 1'b1;
      fwd_valid_q            <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fwd_addr_q <= mem_waddr;
      fwd_data_q <= mem_wdata;
    end
  end

  // A write in the same cycle as the read is not seen by the memory, so the
  // last write is bypassed. An entry never written reads as zero.
  always_comb begin
    if (fwd_valid_q && fwd_addr_q == b_cursor_q) begin
      ent_rd = fwd_data_q;
    end else if (led_valid_q[b_cursor_q]) begin
      ent_rd = led_rdata_q;
    end else begin
      ent_rd = '0;
    end
  end

  always_comb begin
    logic              ch;
    logic [3:0]        nib;
    led_entry_t        ent_nx;
    logic [PULSE_AW-1:0] pidx;

    ch     = b_phase_q[0];
    nib    = ch ? DAC_CMD_CH1 : DAC_CMD_CH0;
    ent_nx = ent_rd;
    pidx   = b_cmd_q.index[PULSE_AW-1:0];

    led_drive_d   = led_drive_q;
    pulse_drive_d = pulse_drive_q;
    pulse_left_d  = pulse_left_q;
    dac_sent_d    = dac_sent_q;
    dac_target_d  = dac_target_q;
    res_d         = '0;
    mem_we        = 1'b0;
    mem_waddr     = b_cursor_q;
    mem_wdata     = ent_rd;

    unique case (b_cmd_q.func)
      FUNC_TICK: begin
        if (force_zero_q) begin
          dac_target_d[ch]     = '0;
          dac_sent_d[ch]       = '0;
          res_d.dac_word_valid = 1'b1;
          res_d.dac_word       = {nib, 12'd0};
        end else if (dac_sent_q[ch] != dac_target_q[ch]) begin
          dac_sent_d[ch]       = dac_target_q[ch];
          res_d.dac_word_valid = 1'b1;
          res_d.dac_word       = {nib, dac_target_q[ch]};
        end

        if (b_blank_q == '0) begin
          if (ent_rd.on_left != 8'd0) begin
            led_drive_d[b_cursor_q] = 1'b1;
            if (ent_rd.on_left != COUNT_HOLD) begin
              ent_nx.on_left = ent_rd.on_left - 8'd1;
            end
          end else begin
            led_drive_d[b_cursor_q] = 1'b0;
            if (ent_rd.off_left != 8'd0) begin
              ent_nx.off_left = ent_rd.off_left - 8'd1;
              // The off phase has run out: the blink cycle starts over.
              if (ent_rd.off_left == 8'd1) begin
                ent_nx.on_left  = ent_rd.on_reload;
                ent_nx.off_left = ent_rd.off_reload;
              end
            end
          end
          mem_we    = b_adv;
          mem_wdata = ent_nx;
        end else begin
          led_drive_d[b_cursor_q] = 1'b0;
        end

        if (b_phase_q == 2'd0) begin
          for (int i = 0; i < PULSE_COUNT; i++) begin
            if (pulse_left_q[i] != 8'd0) begin
              pulse_drive_d[i] = 1'b1;
              if (pulse_left_q[i] != COUNT_HOLD) begin
                pulse_left_d[i] = pulse_left_q[i] - 8'd1;
              end
            end else begin
              pulse_drive_d[i] = 1'b0;
            end
          end
        end
      end
      FUNC_LED: begin
        if (int'(b_cmd_q.index) < LED_COUNT) begin
          mem_we    = b_adv;
          mem_waddr = b_cmd_q.index[LED_AW-1:0];
          mem_wdata = '{on_left:    b_cmd_q.on_time,
                        off_left:   b_cmd_q.off_time,
                        on_reload:  b_cmd_q.on_time,
                        off_reload: b_cmd_q.off_time};
        end
      end
      FUNC_PULSE: begin
        if (int'(b_cmd_q.index) < PULSE_COUNT) begin
          pulse_left_d[pidx] = (b_cmd_q.value > 12'd255) ? COUNT_HOLD : b_cmd_q.value[7:0];
          // Triggers go high at once; the gates wait for the next pulse service.
          if (int'(b_cmd_q.index) >= 2 && pulse_left_d[pidx] != 8'd0) begin
            pulse_drive_d[pidx] = 1'b1;
          end
        end
      end
      FUNC_CV: begin
        if (int'(b_cmd_q.index) < 2) begin
          dac_target_d[b_cmd_q.index[0]] = b_cmd_q.value;
        end
      end
      default: begin
      end
    endcase

    res_d.led_lines   = 12'(led_drive_d);
    res_d.pulse_lines = 8'(pulse_drive_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_drive_q   <= '0;
      pulse_drive_q <= '0;
      pulse_left_q  <= '0;
      dac_sent_q    <= '0;
      dac_target_q  <= {DAC_MID, DAC_MID};
    end else if (b_adv) begin
      led_drive_q   <= led_drive_d;
      pulse_drive_q <= pulse_drive_d;
      pulse_left_q  <= pulse_left_d;
      dac_sent_q    <= dac_sent_d;
      dac_target_q  <= dac_target_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_q <= res_d;
    end
  end

  `ASSERT_CHECK(a_stall_blocks_input, b_valid_q && !b_adv |-> !cmd_i.ready, "input taken while work stage stalls")
  `ASSERT_CHECK(a_force_sends_word, b_adv && b_cmd_q.func == FUNC_TICK && force_zero_q |=> out_valid_q && out_q.dac_word_valid, "force mode tick sent no DAC word")
  `ASSERT_CHECK(a_cursor_wrap, cmd_fire && cmd_i.data.func == FUNC_TICK && cursor_q == LED_AW'(LED_COUNT - 1) |=> cursor_q == '0, "LED cursor did not wrap")
  `ASSERT_NEVER(a_blank_range, int'(blank_sweep_q) >= BLANK_SWEEPS, "blank sweep counter out of range")

endmodule
